// ===== src/lpfb_pkg.sv =====
// Package for the page-organized LCD frame buffer drawer.
// Holds geometry constants, command codes, operation codes, shared-unit types and the font.
// No dependencies; every other file of the block imports it.
package lpfb_pkg;

   localparam int COLUMNS    = 84;
   localparam int BANKS      = 6;
   localparam int STORE_SIZE = COLUMNS * BANKS;
   localparam int ADDR_W     = $clog2(STORE_SIZE);
   // Wide enough for bank * COLUMNS + column before reduction, and for addr + 1.
   localparam int LIN_W      = $clog2(7 * COLUMNS + 128 + STORE_SIZE);
   localparam int CLEAR_BEATS = 2 * (BANKS + 2);
   localparam int CNT_W      = $clog2(CLEAR_BEATS + 1);
   localparam int BANK_W     = 3;
   localparam int COL_W      = 7;
   localparam int LINE_W     = 6;
   localparam int GLYPH_COUNT = 97;
   localparam int GLYPH_IDX_W = $clog2(GLYPH_COUNT);
   localparam int GLYPH_W    = 40;

   // Controller command bytes.
   localparam logic [7:0] CMD_SET_X = 8'h80;
   localparam logic [7:0] CMD_SET_Y = 8'h40;
   localparam logic [7:0] CMD_EXT   = 8'h21;
   localparam logic [7:0] CMD_BASIC = 8'h20;
   localparam logic [7:0] FIRST_CHAR = 8'd32;

   typedef enum logic [2:0] {
      OP_GOTO     = 3'd0,
      OP_CLEAR    = 3'd1,
      OP_PUT_CHAR = 3'd2,
      OP_SET_PIX  = 3'd3,
      OP_CONTRAST = 3'd4
   } op_type;

   // Request to the shared add / compare / subtract unit.
   typedef struct packed {
      logic [LIN_W-1:0] a;
      logic             inc;
      logic [LIN_W-1:0] modulus;
   } alu_req_type;

   typedef struct packed {
      logic [LIN_W-1:0] result;
      logic             wrap;
   } alu_rsp_type;

   // Five glyph columns per character, first column in the top byte.
   localparam logic [GLYPH_W-1:0] GLYPH_ROM [GLYPH_COUNT] = '{
      40'h0000000000, 40'h00002f0000, 40'h0007000700, 40'h147f147f14, 40'h242a7f2a12,
      40'h3234081626, 40'h3649552250, 40'h0005030000, 40'h001c224100, 40'h0041221c00,
      40'h14083E0814, 40'h08083E0808, 40'h0000503000, 40'h1010101010, 40'h0060600000,
      40'h2010080402, 40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
      40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503, 40'h3649494936,
      40'h064949291E, 40'h0036360000, 40'h0056360000, 40'h0814224100, 40'h1414141414,
      40'h0041221408, 40'h0201510906, 40'h324959513E, 40'h7E1111117E, 40'h7F49494936,
      40'h3E41414122, 40'h7F4141221C, 40'h7F49494941, 40'h7F09090901, 40'h3E4149497A,
      40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241, 40'h7F40404040,
      40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E, 40'h7F09090906, 40'h3E4151215E,
      40'h7F09192946, 40'h4649494931, 40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F,
      40'h3F4038403F, 40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007F414100,
      40'h552A552A55, 40'h0041417F00, 40'h0402010204, 40'h4040404040, 40'h0001020400,
      40'h2054545478, 40'h7F48444438, 40'h3844444420, 40'h384444487F, 40'h3854545418,
      40'h087E090102, 40'h0C5252523E, 40'h7F08040478, 40'h00447D4000, 40'h2040443D00,
      40'h7F10284400, 40'h00417F4000, 40'h7C04180478, 40'h7C08040478, 40'h3844444438,
      40'h7C14141408, 40'h081414187C, 40'h7C08040408, 40'h4854545420, 40'h043F444020,
      40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C, 40'h4428102844, 40'h0C5050503C,
      40'h4464544C44, 40'h007F3E1C08, 40'h081C3E7F00, 40'h087C7E7C08, 40'h103E7E3E10,
      40'h3E3E3E3E3E, 40'h007F3E1C08
   };

   // Codes outside the font give a blank glyph.
   function automatic logic [GLYPH_W-1:0] glyph_lookup(input logic [7:0] code);
      logic [7:0] idx;
      idx = code - FIRST_CHAR;
      if (code >= FIRST_CHAR && idx < 8'(GLYPH_COUNT)) begin
         return GLYPH_ROM[idx[GLYPH_IDX_W-1:0]];
      end
      return '0;
   endfunction

endpackage

// ===== src/lpfb_if.sv =====
// Valid/ready channel interfaces for the LCD frame buffer drawer.
// Depends on lpfb_pkg for field widths.
interface lpfb_req_if;
   import lpfb_pkg::*;
   logic              valid;
   logic              ready;
   logic [2:0]        operation;
   logic [COL_W-1:0]  column;
   logic [LINE_W-1:0] line;
   logic [7:0]        character;
   logic [6:0]        contrast_level;

   modport source (output valid, operation, column, line, character, contrast_level,
                   input ready);
   modport sink   (input valid, operation, column, line, character, contrast_level,
                   output ready);
endinterface

interface lpfb_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] display_byte;
   logic       is_data;
   logic       last;

   modport source (output valid, display_byte, is_data, last, input ready);
   modport sink   (input valid, display_byte, is_data, last, output ready);
endinterface

// ===== src/lpfb_store.sv =====
// Frame store: one byte per column of one bank, single address, registered read.
// Depends on lpfb_pkg for the store size.
module lpfb_store (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic                       rd_en,
   input  logic [lpfb_pkg::ADDR_W-1:0] addr,
   input  logic [7:0]                 wr_data,
   output logic [7:0]                 rd_data
);
   import lpfb_pkg::*;

   logic [7:0] mem [STORE_SIZE];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== src/lpfb_alu.sv =====
// Shared add / compare / conditional-subtract unit of the drawer.
// Depends on lpfb_pkg for the request and response types.
module lpfb_alu (
   input  lpfb_pkg::alu_req_type req,
   output lpfb_pkg::alu_rsp_type rsp
);
   import lpfb_pkg::*;

   logic [LIN_W-1:0] sum;

   // One step of a modular increment, a modular reduction or a division by subtraction.
   always_comb begin
      sum        = req.a + LIN_W'(req.inc);
      rsp.wrap   = (sum >= req.modulus);
      rsp.result = rsp.wrap ? (sum - req.modulus) : sum;
   end
endmodule

// ===== src/lcd_page_frame_buffer_drawer.sv =====
// Top level of the page-organized monochrome LCD drawer: sequencer and output register.
// Depends on lpfb_pkg, lpfb_if, lpfb_store and lpfb_alu.
//
// The drawer takes one drawing operation per request beat and answers with the command
// and data bytes for the display controller, one byte per response beat, with last set
// on the final byte of each operation. Operations are handled one at a time: req ready is
// high only while the sequencer is idle. The modular increment, the reduction modulo the
// store size and the split of the advanced text cursor into bank and column all run
// through a single add/compare/subtract unit, one step per cycle, and the frame store
// has one port, so one store byte is written or read per cycle. Set pixel and put
// character take an extra reduction step when their starting address lies past the end
// of the store. After reset, and on every clear operation, the store is zeroed by a
// sweep of one byte per cycle, during which no request is taken; clear then sends its
// 16 command bytes. Codes 5 to 7 are accepted and produce no bytes. Out-of-range
// positions wrap modulo the store size.
module lcd_page_frame_buffer_drawer (
   input logic       clock,
   input logic       reset,
   lpfb_req_if.sink   req_bus,
   lpfb_rsp_if.source rsp_bus
);
   import lpfb_pkg::*;

   typedef enum logic [9:0] {
      ST_SWEEP  = 10'b0000000001,
      ST_IDLE   = 10'b0000000010,
      ST_REDUCE = 10'b0000000100,
      ST_PUT    = 10'b0000001000,
      ST_READ   = 10'b0000010000,
      ST_RDATA  = 10'b0000100000,
      ST_DIV    = 10'b0001000000,
      ST_CMD    = 10'b0010000000,
      ST_PIX_WR = 10'b0100000000,
      ST_DONE   = 10'b1000000000
   } state_type;

   state_type            state_ff, state_in;
   op_type               op_ff, op_in;
   logic [COL_W-1:0]     col_ff, col_in;
   logic [LINE_W-1:0]    line_ff, line_in;
   logic [6:0]           level_ff, level_in;
   logic [GLYPH_W-1:0]   glyph_ff, glyph_in;
   logic [7:0]           pix_ff, pix_in;
   logic [LIN_W-1:0]     addr_ff, addr_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [BANK_W-1:0]    quot_ff, quot_in;
   logic [BANK_W-1:0]    cur_bank_ff, cur_bank_in;
   logic [COL_W-1:0]     cur_col_ff, cur_col_in;
   logic                 clear_pend_ff, clear_pend_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [7:0]           rsp_byte_ff, rsp_byte_in;
   logic                 rsp_data_ff, rsp_data_in;
   logic                 rsp_last_ff, rsp_last_in;

   alu_req_type          alu_req;
   alu_rsp_type          alu_rsp;

   logic                 mem_wr_en, mem_rd_en;
   logic [7:0]           mem_wr_data, mem_rd_data;

   logic                 req_fire;
   logic                 out_free;
   logic                 out_load;
   logic [7:0]           out_byte;
   logic                 out_data;
   logic                 out_last;

   logic [7:0]           cmd_byte;
   logic                 cmd_data;
   logic [CNT_W-1:0]     cmd_count;
   logic [CNT_W-2:0]     clr_pair;
   logic [BANK_W-1:0]    clr_bank;
   logic [LIN_W-1:0]     pix_lin, put_lin;

   lpfb_alu u_alu (
      .req (alu_req),
      .rsp (alu_rsp)
   );

   lpfb_store u_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .rd_en   (mem_rd_en),
      .addr    (addr_ff[ADDR_W-1:0]),
      .wr_data (mem_wr_data),
      .rd_data (mem_rd_data)
   );

   assign req_bus.ready     = (state_ff == ST_IDLE);
   assign req_fire          = req_bus.valid && req_bus.ready;
   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.display_byte = rsp_byte_ff;
   assign rsp_bus.is_data      = rsp_data_ff;
   assign rsp_bus.last         = rsp_last_ff;
   // The output register can take a new beat when empty or being emptied this cycle.
   assign out_free = !rsp_valid_ff || rsp_bus.ready;

   // Linear store addresses before reduction modulo the store size.
   assign pix_lin = LIN_W'(req_bus.line[LINE_W-1:3] * COLUMNS) + LIN_W'(req_bus.column);
   assign put_lin = LIN_W'(cur_bank_ff * COLUMNS) + LIN_W'(cur_col_ff);

   // The clear sequence is pairs of goto commands: bank 0, banks 0 to BANKS-1, bank 0.
   assign clr_pair = cnt_ff[CNT_W-1:1];
   always_comb begin
      if (clr_pair == '0 || clr_pair == (CNT_W-1)'(BANKS + 1)) begin
         clr_bank = '0;
      end else begin
         clr_bank = BANK_W'(clr_pair - (CNT_W-1)'(1));
      end
   end

   // Command beats of the operations that only send a short fixed list.
   always_comb begin
      cmd_byte  = CMD_BASIC;
      cmd_data  = 1'b0;
      cmd_count = CNT_W'(3);
      unique case (op_ff)
         OP_GOTO: begin
            cmd_count = CNT_W'(2);
            cmd_byte  = (cnt_ff == '0) ? (CMD_SET_X | {1'b0, col_ff})
                                       : (CMD_SET_Y | {2'b00, line_ff});
         end
         OP_CLEAR: begin
            cmd_count = CNT_W'(CLEAR_BEATS);
            cmd_byte  = cnt_ff[0] ? (CMD_SET_Y | {5'b00000, clr_bank}) : CMD_SET_X;
         end
         OP_SET_PIX: begin
            if (cnt_ff == '0) begin
               cmd_byte = CMD_SET_X | {1'b0, col_ff};
            end else if (cnt_ff == CNT_W'(1)) begin
               cmd_byte = CMD_SET_Y | {5'b00000, line_ff[LINE_W-1:3]};
            end else begin
               cmd_byte = pix_ff;
               cmd_data = 1'b1;
            end
         end
         OP_CONTRAST: begin
            if (cnt_ff == '0) begin
               cmd_byte = CMD_EXT;
            end else if (cnt_ff == CNT_W'(1)) begin
               cmd_byte = CMD_SET_X | {1'b0, level_ff};
            end else begin
               cmd_byte = CMD_BASIC;
            end
         end
         default: begin
            cmd_count = CNT_W'(1);
            cmd_byte  = CMD_BASIC;
         end
      endcase
   end

   // Sequencer.
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      col_in        = col_ff;
      line_in       = line_ff;
      level_in      = level_ff;
      glyph_in      = glyph_ff;
      pix_in        = pix_ff;
      addr_in       = addr_ff;
      cnt_in        = cnt_ff;
      quot_in       = quot_ff;
      cur_bank_in   = cur_bank_ff;
      cur_col_in    = cur_col_ff;
      clear_pend_in = clear_pend_ff;

      alu_req.a       = addr_ff;
      alu_req.inc     = 1'b0;
      alu_req.modulus = LIN_W'(STORE_SIZE);

      mem_wr_en   = 1'b0;
      mem_rd_en   = 1'b0;
      mem_wr_data = '0;

      out_load = 1'b0;
      out_byte = cmd_byte;
      out_data = cmd_data;
      out_last = 1'b0;

      unique case (state_ff)
         ST_SWEEP: begin
            // Zero one store byte per cycle; the increment wraps after the last one.
            mem_wr_en   = 1'b1;
            alu_req.inc = 1'b1;
            addr_in     = alu_rsp.result;
            if (alu_rsp.wrap) begin
               cnt_in        = '0;
               clear_pend_in = 1'b0;
               state_in      = clear_pend_ff ? ST_CMD : ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               op_in    = op_type'(req_bus.operation);
               col_in   = req_bus.column;
               line_in  = req_bus.line;
               level_in = req_bus.contrast_level;
               glyph_in = glyph_lookup(req_bus.character);
               cnt_in   = '0;
               quot_in  = '0;
               unique case (req_bus.operation)
                  OP_GOTO: begin
                     cur_col_in  = req_bus.column;
                     cur_bank_in = req_bus.line[BANK_W-1:0];
                     state_in    = ST_CMD;
                  end
                  OP_CLEAR: begin
                     cur_col_in    = '0;
                     cur_bank_in   = '0;
                     addr_in       = '0;
                     clear_pend_in = 1'b1;
                     state_in      = ST_SWEEP;
                  end
                  OP_PUT_CHAR: begin
                     addr_in  = put_lin;
                     state_in = ST_REDUCE;
                  end
                  OP_SET_PIX: begin
                     cur_col_in  = req_bus.column;
                     cur_bank_in = req_bus.line[LINE_W-1:3];
                     addr_in     = pix_lin;
                     state_in    = ST_REDUCE;
                  end
                  OP_CONTRAST: begin
                     state_in = ST_CMD;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_REDUCE: begin
            // Subtract the store size until the address lies inside the store.
            if (alu_rsp.wrap) begin
               addr_in = alu_rsp.result;
            end else begin
               state_in = (op_ff == OP_PUT_CHAR) ? ST_PUT : ST_READ;
            end
         end
         ST_PUT: begin
            // Write a glyph column shifted one pixel down (one bit left) and send the same byte.
            out_byte = {glyph_ff[GLYPH_W-2:GLYPH_W-8], 1'b0};
            out_data = 1'b1;
            if (out_free) begin
               out_load    = 1'b1;
               mem_wr_en   = 1'b1;
               mem_wr_data = out_byte;
               alu_req.inc = 1'b1;
               addr_in     = alu_rsp.result;
               glyph_in    = {glyph_ff[GLYPH_W-9:0], 8'h00};
               cnt_in      = cnt_ff + CNT_W'(1);
               if (cnt_ff == CNT_W'(4)) begin
                  state_in = ST_READ;
               end
            end
         end
         ST_READ: begin
            mem_rd_en = 1'b1;
            state_in  = ST_RDATA;
            if (op_ff == OP_PUT_CHAR) begin
               alu_req.inc = 1'b1;
               addr_in     = alu_rsp.result;
            end
         end
         ST_RDATA: begin
            if (op_ff == OP_SET_PIX) begin
               pix_in   = mem_rd_data | (8'h01 << line_ff[2:0]);
               state_in = ST_PIX_WR;
            end else begin
               // The two store bytes after the glyph go out unchanged.
               out_byte = mem_rd_data;
               out_data = 1'b1;
               out_last = (cnt_ff == CNT_W'(6));
               if (out_free) begin
                  out_load = 1'b1;
                  cnt_in   = cnt_ff + CNT_W'(1);
                  state_in = (cnt_ff == CNT_W'(6)) ? ST_DIV : ST_READ;
               end
            end
         end
         ST_PIX_WR: begin
            mem_wr_en   = 1'b1;
            mem_wr_data = pix_ff;
            cnt_in      = '0;
            state_in    = ST_CMD;
         end
         ST_DIV: begin
            // Split the advanced linear cursor into bank and column by repeated subtraction.
            alu_req.modulus = LIN_W'(COLUMNS);
            if (alu_rsp.wrap) begin
               addr_in = alu_rsp.result;
               quot_in = quot_ff + BANK_W'(1);
            end else begin
               cur_bank_in = quot_ff;
               cur_col_in  = addr_ff[COL_W-1:0];
               state_in    = ST_DONE;
            end
         end
         ST_CMD: begin
            out_last = (cnt_ff == cmd_count - CNT_W'(1));
            if (out_free) begin
               out_load = 1'b1;
               cnt_in   = cnt_ff + CNT_W'(1);
               if (out_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Output register: holds one beat until the sink takes it.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
         rsp_byte_in  = out_byte;
         rsp_data_in  = out_data;
         rsp_last_in  = out_last;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_SWEEP;
         addr_ff       <= '0;
         cnt_ff        <= '0;
         quot_ff       <= '0;
         cur_bank_ff   <= '0;
         cur_col_ff    <= '0;
         clear_pend_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         op_ff         <= OP_GOTO;
      end else begin
         state_ff      <= state_in;
         addr_ff       <= addr_in;
         cnt_ff        <= cnt_in;
         quot_ff       <= quot_in;
         cur_bank_ff   <= cur_bank_in;
         cur_col_ff    <= cur_col_in;
         clear_pend_ff <= clear_pend_in;
         rsp_valid_ff  <= rsp_valid_in;
         op_ff         <= op_in;
      end
   end

   always_ff @(posedge clock) begin
      col_ff      <= col_in;
      line_ff     <= line_in;
      level_ff    <= level_in;
      glyph_ff    <= glyph_in;
      pix_ff      <= pix_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end
endmodule

// ===== tb/lpfb_drawer_checker.sv =====
// Scoreboard for the LCD frame buffer drawer: tracks frame store and cursor, predicts
// the display bytes of every accepted drawing operation and compares the response beats.
// Depends on lpfb_pkg (operation codes) and lpfb_if (channel interfaces).
module lpfb_drawer_checker (
   input  logic clock,
   input  logic reset,
   lpfb_req_if  req_bus,
   lpfb_rsp_if  rsp_bus,
   output int   failures,
   output int   pending
);
   import lpfb_pkg::*;

   localparam int DISP_COLUMNS = 84;
   localparam int DISP_BANKS   = 6;
   localparam int FRAME_BYTES  = DISP_COLUMNS * DISP_BANKS;
   localparam int FONT_SIZE    = 97;
   localparam int FONT_BASE    = 32;

   localparam logic [7:0] SET_COLUMN_CMD = 8'h80;
   localparam logic [7:0] SET_BANK_CMD   = 8'h40;
   localparam logic [7:0] EXTENDED_CMD   = 8'h21;
   localparam logic [7:0] BASIC_CMD      = 8'h20;

   // Five columns per glyph, leftmost column in the top byte, bit 0 on top.
   localparam logic [39:0] FONT [FONT_SIZE] = '{
      40'h0000000000, 40'h00002f0000, 40'h0007000700, 40'h147f147f14, 40'h242a7f2a12,
      40'h3234081626, 40'h3649552250, 40'h0005030000, 40'h001c224100, 40'h0041221c00,
      40'h14083e0814, 40'h08083e0808, 40'h0000503000, 40'h1010101010, 40'h0060600000,
      40'h2010080402, 40'h3e5149453e, 40'h00427f4000, 40'h4261514946, 40'h2141454b31,
      40'h1814127f10, 40'h2745454539, 40'h3c4a494930, 40'h0171090503, 40'h3649494936,
      40'h064949291e, 40'h0036360000, 40'h0056360000, 40'h0814224100, 40'h1414141414,
      40'h0041221408, 40'h0201510906, 40'h324959513e, 40'h7e1111117e, 40'h7f49494936,
      40'h3e41414122, 40'h7f4141221c, 40'h7f49494941, 40'h7f09090901, 40'h3e4149497a,
      40'h7f0808087f, 40'h00417f4100, 40'h2040413f01, 40'h7f08142241, 40'h7f40404040,
      40'h7f020c027f, 40'h7f0408107f, 40'h3e4141413e, 40'h7f09090906, 40'h3e4151215e,
      40'h7f09192946, 40'h4649494931, 40'h01017f0101, 40'h3f4040403f, 40'h1f2040201f,
      40'h3f4038403f, 40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007f414100,
      40'h552a552a55, 40'h0041417f00, 40'h0402010204, 40'h4040404040, 40'h0001020400,
      40'h2054545478, 40'h7f48444438, 40'h3844444420, 40'h384444487f, 40'h3854545418,
      40'h087e090102, 40'h0c5252523e, 40'h7f08040478, 40'h00447d4000, 40'h2040443d00,
      40'h7f10284400, 40'h00417f4000, 40'h7c04180478, 40'h7c08040478, 40'h3844444438,
      40'h7c14141408, 40'h081414187c, 40'h7c08040408, 40'h4854545420, 40'h043f444020,
      40'h3c4040207c, 40'h1c2040201c, 40'h3c4030403c, 40'h4428102844, 40'h0c5050503c,
      40'h4464544c44, 40'h007f3e1c08, 40'h081c3e7f00, 40'h087c7e7c08, 40'h103e7e3e10,
      40'h3e3e3e3e3e, 40'h007f3e1c08
   };

   typedef struct packed {
      logic [7:0] data;
      logic       is_data;
      logic       last;
   } lcd_beat_type;

   lcd_beat_type lcd_bytes_due[$];
   logic [7:0]   frame [FRAME_BYTES];
   logic [2:0]   cursor_bank;
   logic [6:0]   cursor_column;

   function automatic int frame_index(input int bank, input int column);
      return (bank * DISP_COLUMNS + column) % FRAME_BYTES;
   endfunction

   function automatic void queue_byte(input logic [7:0] data, input logic is_data,
                                      input logic last);
      lcd_beat_type beat;
      beat = '{data: data, is_data: is_data, last: last};
      lcd_bytes_due.push_back(beat);
   endfunction

   function automatic void queue_goto(input logic [6:0] column, input logic [5:0] bank,
                                      input logic last);
      queue_byte(SET_COLUMN_CMD | {1'b0, column}, 1'b0, 1'b0);
      queue_byte(SET_BANK_CMD | {2'b00, bank}, 1'b0, last);
      cursor_column = column;
      cursor_bank   = bank[2:0];
   endfunction

   function automatic void draw_operation(input logic [2:0] op, input logic [6:0] column,
                                          input logic [5:0] line, input logic [7:0] code,
                                          input logic [6:0] level);
      int          base;
      int          row;
      logic [39:0] glyph;
      logic [7:0]  glyph_col;
      case (op)
         OP_GOTO: begin
            queue_goto(column, line, 1'b1);
         end
         OP_CLEAR: begin
            foreach (frame[i]) frame[i] = 8'h00;
            queue_goto(7'd0, 6'd0, 1'b0);
            for (int b = 0; b < DISP_BANKS; b++) queue_goto(7'd0, 6'(b), 1'b0);
            queue_goto(7'd0, 6'd0, 1'b1);
         end
         OP_PUT_CHAR: begin
            base  = frame_index(cursor_bank, cursor_column);
            glyph = '0;
            if (code >= FONT_BASE && code - FONT_BASE < FONT_SIZE) begin
               glyph = FONT[code - FONT_BASE];
            end
            // The glyph lands one pixel below the bank top.
            for (int i = 0; i < 5; i++) begin
               glyph_col = glyph[39 - 8 * i -: 8];
               frame[(base + i) % FRAME_BYTES] = {glyph_col[6:0], 1'b0};
            end
            for (int i = 0; i < 7; i++) begin
               queue_byte(frame[(base + i) % FRAME_BYTES], 1'b1, i == 6);
            end
            base          = (base + 7) % FRAME_BYTES;
            cursor_bank   = 3'(base / DISP_COLUMNS);
            cursor_column = 7'(base % DISP_COLUMNS);
         end
         OP_SET_PIX: begin
            row  = int'(line) / 8;
            base = frame_index(row, column);
            frame[base][line[2:0]] = 1'b1;
            queue_goto(column, 6'(row), 1'b0);
            queue_byte(frame[base], 1'b1, 1'b1);
         end
         OP_CONTRAST: begin
            queue_byte(EXTENDED_CMD, 1'b0, 1'b0);
            queue_byte(SET_COLUMN_CMD | {1'b0, level}, 1'b0, 1'b0);
            queue_byte(BASIC_CMD, 1'b0, 1'b1);
         end
         default: begin
         end
      endcase
   endfunction

   always @(posedge clock) begin : watch
      lcd_beat_type seen;
      lcd_beat_type want;
      if (reset) begin
         lcd_bytes_due.delete();
         foreach (frame[i]) frame[i] = 8'h00;
         cursor_bank   = '0;
         cursor_column = '0;
         failures <= 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            seen = '{data: rsp_bus.display_byte, is_data: rsp_bus.is_data,
                     last: rsp_bus.last};
            if (lcd_bytes_due.size() == 0) begin
               $display("%0t: expected no beat, got byte %02h is_data %b last %b",
                        $time, seen.data, seen.is_data, seen.last);
               failures <= failures + 1;
            end else begin
               want = lcd_bytes_due.pop_front();
               if (seen.data !== want.data || seen.is_data !== want.is_data ||
                   seen.last !== want.last) begin
                  $display("%0t: expected byte %02h is_data %b last %b, got %02h %b %b",
                           $time, want.data, want.is_data, want.last,
                           seen.data, seen.is_data, seen.last);
                  failures <= failures + 1;
               end
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            draw_operation(req_bus.operation, req_bus.column, req_bus.line,
                           req_bus.character, req_bus.contrast_level);
         end
      end
      pending <= lcd_bytes_due.size();
   end

endmodule

// ===== tb/lcd_page_frame_buffer_drawer_test.sv =====
// Top of the LCD frame buffer drawer testbench: clock, reset, drawing stimulus and verdict.
// Depends on lpfb_pkg, lpfb_if, the drawer itself and lpfb_drawer_checker.
module lcd_page_frame_buffer_drawer_test;
   import lpfb_pkg::*;

   // Codes 5 to 7 are spare operations that the drawer swallows silently.
   localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
   localparam logic [2:0] OP_SPARE_LAST  = 3'd7;

   localparam int RESET_CYCLES  = 7;
   localparam int RANDOM_OPS    = 250;
   localparam int SETTLE_CYCLES = 40;
   // Worst case per operation is a clear: a full store sweep plus 16 beats that may
   // each meet a long response stall. Several times that over all operations.
   localparam int CYCLE_LIMIT   = 1_500_000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   // Request side drivers; all start at known values.
   logic       req_valid          = 1'b0;
   logic [2:0] req_operation      = '0;
   logic [6:0] req_column         = '0;
   logic [5:0] req_line           = '0;
   logic [7:0] req_character      = '0;
   logic [6:0] req_contrast_level = '0;
   logic       rsp_take           = 1'b0;

   // When set, the matching side runs without any idle cycles.
   logic req_calm = 1'b0;
   logic rsp_calm = 1'b0;

   int rsp_stall_left = 0;
   int cycles         = 0;
   int mismatches;
   int bytes_pending;

   lpfb_req_if req_if ();
   lpfb_rsp_if rsp_if ();

   assign req_if.valid          = req_valid;
   assign req_if.operation      = req_operation;
   assign req_if.column         = req_column;
   assign req_if.line           = req_line;
   assign req_if.character      = req_character;
   assign req_if.contrast_level = req_contrast_level;
   assign rsp_if.ready          = rsp_take;

   lcd_page_frame_buffer_drawer i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_if),
      .rsp_bus (rsp_if)
   );

   lpfb_drawer_checker i_checker (
      .clock    (clock),
      .reset    (reset),
      .req_bus  (req_if),
      .rsp_bus  (rsp_if),
      .failures (mismatches),
      .pending  (bytes_pending)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Idle lengths: mostly none, often a short gap, now and then a long pause.
   function automatic int pick_gap(input logic calm);
      int roll;
      roll = $urandom_range(0, 99);
      if (calm || roll < 60) begin
         return 0;
      end
      if (roll < 92) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   // Positions stay on the display most of the time; the rest use the full field width
   // so that wrapping of the store address gets exercised.
   function automatic logic [6:0] pick_column();
      if ($urandom_range(0, 9) == 0) begin
         return 7'($urandom_range(0, 127));
      end
      return 7'($urandom_range(0, 83));
   endfunction

   function automatic logic [5:0] pick_bank();
      if ($urandom_range(0, 9) == 0) begin
         return 6'($urandom_range(0, 63));
      end
      return 6'($urandom_range(0, 5));
   endfunction

   function automatic logic [5:0] pick_pixel_line();
      if ($urandom_range(0, 9) == 0) begin
         return 6'($urandom_range(0, 63));
      end
      return 6'($urandom_range(0, 47));
   endfunction

   // Mostly printable codes, with some outside the font that must draw blank.
   function automatic logic [7:0] pick_character();
      if ($urandom_range(0, 7) == 0) begin
         return 8'($urandom_range(0, 255));
      end
      return 8'($urandom_range(32, 128));
   endfunction

   // The response side stalls at random. Each stall is counted down here so that ready
   // gets exactly one assignment per edge.
   always @(posedge clock) begin : rsp_pacing
      int stall;
      if (rsp_stall_left > 0) begin
         rsp_stall_left <= rsp_stall_left - 1;
         rsp_take       <= 1'b0;
      end else begin
         stall = pick_gap(rsp_calm);
         if (stall > 0) begin
            rsp_stall_left <= stall - 1;
            rsp_take       <= 1'b0;
         end else begin
            rsp_take <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("lcd_page_frame_buffer_drawer_test NOT OK");
         $finish;
      end
   end

   // Presents one operation, holds it until the drawer takes the beat, then possibly
   // leaves the request side idle for a while. With no gap, valid simply stays high and
   // the next call replaces the payload at the same edge.
   task automatic send_op(input logic [2:0] op, input logic [6:0] column,
                          input logic [5:0] line, input logic [7:0] code,
                          input logic [6:0] level);
      int gap;
      req_valid          <= 1'b1;
      req_operation      <= op;
      req_column         <= column;
      req_line           <= line;
      req_character      <= code;
      req_contrast_level <= level;
      do @(posedge clock); while (!req_if.ready);
      gap = pick_gap(req_calm);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Operation helpers fill the fields that the operation ignores with random bits.
   task automatic send_goto(input logic [6:0] column, input logic [5:0] bank);
      send_op(OP_GOTO, column, bank, 8'($urandom), 7'($urandom));
   endtask

   task automatic send_char(input logic [7:0] code);
      send_op(OP_PUT_CHAR, 7'($urandom), 6'($urandom), code, 7'($urandom));
   endtask

   task automatic send_pixel(input logic [6:0] column, input logic [5:0] line);
      send_op(OP_SET_PIX, column, line, 8'($urandom), 7'($urandom));
   endtask

   task automatic send_contrast(input logic [6:0] level);
      send_op(OP_CONTRAST, 7'($urandom), 6'($urandom), 8'($urandom), level);
   endtask

   task automatic send_other(input logic [2:0] op);
      send_op(op, 7'($urandom), 6'($urandom), 8'($urandom), 7'($urandom));
   endtask

   // Stops offering operations until every predicted beat has come back.
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (bytes_pending != 0);
   endtask

   initial begin : stimulus
      int  counted;
      int  run;
      int  roll;
      logic drained;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed part. Text at the origin, both ends of the contrast range.
      send_goto(7'd0, 6'd0);
      send_char(8'd65);
      send_contrast(7'd0);
      send_contrast(7'd127);
      // The last column of the last bank: the glyph and its trailing bytes wrap around
      // the end of the store, and the cursor wraps to the first bank.
      send_goto(7'd83, 6'd5);
      send_char(8'd128);
      // First glyph (blank), codes below and far above the font, and the next-to-last glyph.
      send_char(8'd32);
      send_char(8'd0);
      send_char(8'd255);
      send_char(8'd127);
      // A goto beyond the display: raw bits in the commands, wrapped store address.
      send_goto(7'd127, 6'd63);
      send_char(8'd90);
      // Text that runs off the end of a bank into the next one.
      send_goto(7'd80, 6'd1);
      send_char(8'd126);
      // Pixels: two bits of the same byte must merge, corners and an off-screen spot.
      send_pixel(7'd0, 6'd0);
      send_pixel(7'd0, 6'd7);
      send_pixel(7'd83, 6'd47);
      send_pixel(7'd127, 6'd63);
      // Spare codes are taken but answer nothing.
      send_other(OP_SPARE_FIRST);
      send_other(OP_SPARE_LAST);
      send_other(OP_CLEAR);
      // After the clear the store must read back empty apart from the new pixel.
      send_pixel(7'd5, 6'd20);
      send_char(8'd33);
      send_contrast(7'd85);

      // Random part, made mostly of the sequences a real display driver issues: a goto
      // followed by a run of characters, or a burst of pixels.
      counted = 0;
      drained = 1'b0;
      while (counted < RANDOM_OPS) begin
         req_calm = ($urandom_range(0, 5) == 0);
         rsp_calm = ($urandom_range(0, 5) == 0);
         roll     = $urandom_range(0, 99);
         if (roll < 45) begin
            send_goto(pick_column(), pick_bank());
            run = $urandom_range(2, 10);
            repeat (run) send_char(pick_character());
            counted += run + 1;
         end else if (roll < 70) begin
            run = $urandom_range(2, 8);
            repeat (run) send_pixel(pick_column(), pick_pixel_line());
            counted += run;
         end else if (roll < 73) begin
            send_other(OP_CLEAR);
            counted++;
         end else if (roll < 80) begin
            send_contrast(7'($urandom));
            counted++;
         end else if (roll < 85) begin
            // Noise: a spare code, not counted toward the operation budget.
            send_other(3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST)));
         end else begin
            // Any real operation with unconstrained field bits.
            send_op(3'($urandom_range(OP_GOTO, OP_CONTRAST)), 7'($urandom), 6'($urandom),
                    8'($urandom), 7'($urandom));
            counted++;
         end
         if (!drained && counted >= RANDOM_OPS / 2) begin
            drain();
            drained = 1'b1;
         end
      end

      req_calm = 1'b0;
      rsp_calm = 1'b0;
      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("lcd_page_frame_buffer_drawer_test OK");
      end else begin
         $display("lcd_page_frame_buffer_drawer_test NOT OK");
      end
      $finish;
   end

endmodule

// ===== files.f =====
src/lpfb_pkg.sv
src/lpfb_if.sv
src/lpfb_store.sv
src/lpfb_alu.sv
src/lcd_page_frame_buffer_drawer.sv
tb/lpfb_drawer_checker.sv
tb/lcd_page_frame_buffer_drawer_test.sv
